// ===== design/trilin_pkg.sv =====
// Shared widths, types and constants for the trilinear interpolation pipeline.
`timescale 1ns / 1ps

package trilin_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int OFFSET_WIDTH = 16;
   localparam int FRAC_BITS    = 16;
   localparam int SLOPE_WIDTH  = VALUE_WIDTH + 1;
   localparam int DIFF_WIDTH   = SLOPE_WIDTH + 1;
   localparam int PROD_WIDTH   = DIFF_WIDTH + OFFSET_WIDTH + 1;

   localparam int LERP_STAGES  = 3;
   localparam int LERP_LEVELS  = 3;
   localparam int PIPE_STAGES  = 1 + LERP_LEVELS * LERP_STAGES;

   localparam int L1_COUNT     = 10;
   localparam int L2_COUNT     = 5;

   typedef logic signed [VALUE_WIDTH-1:0]  value_type;
   typedef logic signed [SLOPE_WIDTH-1:0]  slope_type;
   typedef logic signed [DIFF_WIDTH-1:0]   diff_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic        [OFFSET_WIDTH-1:0] offset_type;
   typedef logic        [LERP_STAGES-1:0]  lerp_en_type;

   localparam prod_type ROUND_BIAS = PROD_WIDTH'(1) << (OFFSET_WIDTH - 1);

endpackage

// ===== design/trilinear_interp_with_gradient.sv =====
// Top level of the pipelined trilinear interpolator with analytic gradient.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    eight corners, three offsets
// rsp      out        rsp_valid/rsp_ready    interpolated value, three slopes
//
// One transaction enters per cycle unless rsp_ready stalls a full pipeline; its result is offered at the last stage.
// The pipeline is one input stage plus three chained levels of lerp units of three stages each.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall holds only the stages that are full, so bubbles close up and nothing is lost.
`timescale 1ns / 1ps

module trilinear_interp_with_gradient (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  trilin_pkg::value_type  req_corner_000,
   input  trilin_pkg::value_type  req_corner_100,
   input  trilin_pkg::value_type  req_corner_010,
   input  trilin_pkg::value_type  req_corner_110,
   input  trilin_pkg::value_type  req_corner_001,
   input  trilin_pkg::value_type  req_corner_101,
   input  trilin_pkg::value_type  req_corner_011,
   input  trilin_pkg::value_type  req_corner_111,
   input  trilin_pkg::offset_type req_offset_x,
   input  trilin_pkg::offset_type req_offset_y,
   input  trilin_pkg::offset_type req_offset_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output trilin_pkg::value_type  rsp_interp_value,
   output trilin_pkg::slope_type  rsp_slope_x,
   output trilin_pkg::slope_type  rsp_slope_y,
   output trilin_pkg::slope_type  rsp_slope_z
);
   import trilin_pkg::*;

   localparam int L2_BASE = 1 + LERP_STAGES;
   localparam int L3_BASE = 1 + 2 * LERP_STAGES;

   logic [PIPE_STAGES-1:0] vld_ff;
   logic [PIPE_STAGES-1:0] vld_in;
   logic [PIPE_STAGES:0]   en;

   slope_type  c [8];
   slope_type  op_a_in [L1_COUNT];
   slope_type  op_b_in [L1_COUNT];
   slope_type  op_a_ff [L1_COUNT];
   slope_type  op_b_ff [L1_COUNT];
   offset_type fx_ff;
   offset_type fy_ff [L2_BASE];
   offset_type fz_ff [L3_BASE];
   slope_type  slope_dly_ff [LERP_STAGES][3];

   offset_type l1_f [L1_COUNT];
   slope_type  l1_r [L1_COUNT];
   slope_type  l2_a [L2_COUNT];
   slope_type  l2_b [L2_COUNT];
   offset_type l2_f [L2_COUNT];
   slope_type  l2_r [L2_COUNT];
   slope_type  l3_r;

   always_comb begin
      en[PIPE_STAGES] = rsp_ready;
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (en[k]) begin
            vld_in[k] = (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      c[0] = slope_type'(req_corner_000);
      c[1] = slope_type'(req_corner_100);
      c[2] = slope_type'(req_corner_010);
      c[3] = slope_type'(req_corner_110);
      c[4] = slope_type'(req_corner_001);
      c[5] = slope_type'(req_corner_101);
      c[6] = slope_type'(req_corner_011);
      c[7] = slope_type'(req_corner_111);
      op_a_in[0] = c[0];        op_b_in[0] = c[1];
      op_a_in[1] = c[2];        op_b_in[1] = c[3];
      op_a_in[2] = c[4];        op_b_in[2] = c[5];
      op_a_in[3] = c[6];        op_b_in[3] = c[7];
      op_a_in[4] = c[1] - c[0]; op_b_in[4] = c[3] - c[2];
      op_a_in[5] = c[5] - c[4]; op_b_in[5] = c[7] - c[6];
      op_a_in[6] = c[2] - c[0]; op_b_in[6] = c[3] - c[1];
      op_a_in[7] = c[6] - c[4]; op_b_in[7] = c[7] - c[5];
      op_a_in[8] = c[4] - c[0]; op_b_in[8] = c[5] - c[1];
      op_a_in[9] = c[6] - c[2]; op_b_in[9] = c[7] - c[3];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         op_a_ff <= op_a_in;
         op_b_ff <= op_b_in;
         fx_ff   <= req_offset_x;
         fy_ff[0] <= req_offset_y;
         fz_ff[0] <= req_offset_z;
      end
      for (int k = 1; k < L2_BASE; k++) begin
         if (en[k]) begin
            fy_ff[k] <= fy_ff[k-1];
         end
      end
      for (int k = 1; k < L3_BASE; k++) begin
         if (en[k]) begin
            fz_ff[k] <= fz_ff[k-1];
         end
      end
      if (en[L3_BASE]) begin
         slope_dly_ff[0][0] <= l2_r[2];
         slope_dly_ff[0][1] <= l2_r[3];
         slope_dly_ff[0][2] <= l2_r[4];
      end
      for (int k = 1; k < LERP_STAGES; k++) begin
         if (en[L3_BASE+k]) begin
            slope_dly_ff[k] <= slope_dly_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < L1_COUNT; i++) begin
         l1_f[i] = fx_ff;
      end
      l1_f[4] = fy_ff[0];
      l1_f[5] = fy_ff[0];

      l2_a[0] = l1_r[0]; l2_b[0] = l1_r[1]; l2_f[0] = fy_ff[L2_BASE-1];
      l2_a[1] = l1_r[2]; l2_b[1] = l1_r[3]; l2_f[1] = fy_ff[L2_BASE-1];
      l2_a[2] = l1_r[4]; l2_b[2] = l1_r[5]; l2_f[2] = fz_ff[L2_BASE-1];
      l2_a[3] = l1_r[6]; l2_b[3] = l1_r[7]; l2_f[3] = fz_ff[L2_BASE-1];
      l2_a[4] = l1_r[8]; l2_b[4] = l1_r[9]; l2_f[4] = fy_ff[L2_BASE-1];
   end

   for (genvar g = 0; g < L1_COUNT; g++) begin : g_l1
      trilin_lerp u_lerp (
         .clock    (clock),
         .stage_en (en[L2_BASE-1:1]),
         .a        (op_a_ff[g]),
         .b        (op_b_ff[g]),
         .f        (l1_f[g]),
         .result   (l1_r[g])
      );
   end

   for (genvar g = 0; g < L2_COUNT; g++) begin : g_l2
      trilin_lerp u_lerp (
         .clock    (clock),
         .stage_en (en[L3_BASE-1:L2_BASE]),
         .a        (l2_a[g]),
         .b        (l2_b[g]),
         .f        (l2_f[g]),
         .result   (l2_r[g])
      );
   end

   trilin_lerp u_lerp_z (
      .clock    (clock),
      .stage_en (en[PIPE_STAGES-1:L3_BASE]),
      .a        (l2_r[0]),
      .b        (l2_r[1]),
      .f        (fz_ff[L3_BASE-1]),
      .result   (l3_r)
   );

   assign req_ready        = en[0];
   assign rsp_valid        = vld_ff[PIPE_STAGES-1];
   assign rsp_interp_value = l3_r[VALUE_WIDTH-1:0];
   assign rsp_slope_x      = slope_dly_ff[LERP_STAGES-1][0];
   assign rsp_slope_y      = slope_dly_ff[LERP_STAGES-1][1];
   assign rsp_slope_z      = slope_dly_ff[LERP_STAGES-1][2];

   a_full_when_blocked : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&vld_ff) && !rsp_ready))
      else $error("Input blocked while the pipeline has an empty stage.");

   a_count_grows : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !(rsp_valid && rsp_ready))
      |=> ($countones(vld_ff) == $past($countones(vld_ff)) + 1))
      else $error("A transaction was lost or duplicated inside the pipeline.");

   a_count_shrinks : assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && req_ready) && rsp_valid && rsp_ready)
      |=> ($countones(vld_ff) + 1 == $past($countones(vld_ff))))
      else $error("A delivered transaction did not leave the pipeline.");

endmodule

// ===== design/trilin_lerp.sv =====
// Three-stage pipelined linear interpolation with round-to-nearest.
`timescale 1ns / 1ps

module trilin_lerp (
   input  logic                    clock,
   input  trilin_pkg::lerp_en_type stage_en,
   input  trilin_pkg::slope_type   a,
   input  trilin_pkg::slope_type   b,
   input  trilin_pkg::offset_type  f,
   output trilin_pkg::slope_type   result
);
   import trilin_pkg::*;

   diff_type   diff_ff;
   diff_type   diff_in;
   slope_type  a1_ff;
   offset_type f1_ff;
   prod_type   prod_ff;
   prod_type   prod_in;
   slope_type  a2_ff;
   slope_type  result_ff;
   slope_type  result_in;
   prod_type   biased;
   logic signed [OFFSET_WIDTH:0] f_ext;

   always_comb begin
      diff_in   = diff_type'(b) - diff_type'(a);
      f_ext     = $signed({1'b0, f1_ff});
      prod_in   = diff_ff * f_ext;
      biased    = prod_ff + ROUND_BIAS;
      result_in = a2_ff + biased[OFFSET_WIDTH+SLOPE_WIDTH-1:OFFSET_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         diff_ff <= diff_in;
         a1_ff   <= a;
         f1_ff   <= f;
      end
      if (stage_en[1]) begin
         prod_ff <= prod_in;
         a2_ff   <= a1_ff;
      end
      if (stage_en[2]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
